// File: design/utlw_pkg.sv
// Package for the UTF-8 text line wrapper: record types, byte codes, limits.
// No dependencies; used by utlw_core, utf8_text_line_wrapper and the testbench.
`default_nettype none

package utlw_pkg;

  localparam int unsigned MAX_CHARS_DEF = 128;
  localparam int unsigned MAX_LINES_DEF = 8;
  localparam int unsigned MAX_RES       = 5;
  localparam int unsigned RES_CNT_W     = $clog2(MAX_RES + 1);

  localparam logic [7:0] CAP_RESET = 8'd32;

  localparam logic [7:0] BYTE_BACKSLASH = 8'h5C;
  localparam logic [7:0] BYTE_LOWER_R   = 8'h72;
  localparam logic [7:0] BYTE_LOWER_N   = 8'h6E;
  localparam logic [7:0] BYTE_CR        = 8'h0D;
  localparam logic [7:0] BYTE_LF        = 8'h0A;

  localparam logic [7:0] LEAD1_MASK = 8'h80;
  localparam logic [7:0] LEAD1_VAL  = 8'h00;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_VAL  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_VAL  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_VAL  = 8'hF0;

  typedef enum logic {
    REC_LINE    = 1'b0,
    REC_SUMMARY = 1'b1
  } rec_kind_e;

  typedef struct packed {
    rec_kind_e   kind;
    logic [2:0]  line_number;
    logic [6:0]  first_char;
    logic [7:0]  end_char;
    logic [7:0]  total_chars;
    logic [3:0]  total_lines;
  } rec_t;

  // UTF-8 sequence length from the lead byte; invalid leads count as one byte
  function automatic logic [2:0] lead_length(logic [7:0] b);
    logic [2:0] len;
    if ((b & LEAD1_MASK) == LEAD1_VAL) begin
      len = 3'd1;
    end else if ((b & LEAD2_MASK) == LEAD2_VAL) begin
      len = 3'd2;
    end else if ((b & LEAD3_MASK) == LEAD3_VAL) begin
      len = 3'd3;
    end else if ((b & LEAD4_MASK) == LEAD4_VAL) begin
      len = 3'd4;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// File: design/utlw_if.sv
// Request channels of the UTF-8 text line wrapper: byte input and record output.
// No dependencies on other files.
`default_nettype none

interface utlw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       is_final;

  modport source (output valid, output text_byte, output is_final, input ready);
  modport sink   (input valid, input text_byte, input is_final, output ready);
endinterface

interface utlw_out_if;
  logic       valid;
  logic       ready;
  logic       record_kind;
  logic [2:0] line_number;
  logic [6:0] first_char;
  logic [7:0] end_char;
  logic [7:0] total_chars;
  logic [3:0] total_lines;
  logic       run_end;

  modport source (output valid, output record_kind, output line_number, output first_char,
                  output end_char, output total_chars, output total_lines, output run_end,
                  input ready);
  modport sink   (input valid, input record_kind, input line_number, input first_char,
                  input end_char, input total_chars, input total_lines, input run_end,
                  output ready);
endinterface

`default_nettype wire

// File: design/utlw_core.sv
// Wrapper state and single-pass step logic: escape filtering, UTF-8 grouping,
// greedy line closing. Produces up to MAX_RES records per byte. Uses utlw_pkg.
`default_nettype none

module utlw_core #(
  parameter int unsigned MAX_CHARS = utlw_pkg::MAX_CHARS_DEF,
  parameter int unsigned MAX_LINES = utlw_pkg::MAX_LINES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              take_i,
  input  wire logic [7:0]                        text_byte_i,
  input  wire logic                              is_final_i,
  input  wire logic [7:0]                        cap_i,
  output utlw_pkg::rec_t                         res_o [utlw_pkg::MAX_RES],
  output logic [utlw_pkg::RES_CNT_W-1:0]         res_cnt_o
);

  localparam int unsigned CW  = $clog2(MAX_CHARS + 1);
  localparam int unsigned LW  = $clog2(MAX_LINES + 1);
  localparam int unsigned RCW = utlw_pkg::RES_CNT_W;

  typedef struct packed {
    logic          held;
    logic          char_open;
    logic [2:0]    len_exp;
    logic [2:0]    len_seen;
    logic [CW-1:0] idx;
    logic [CW-1:0] line_begin;
    logic [7:0]    units;
    logic [LW-1:0] lines;
  } st_t;

  typedef struct packed {
    st_t            st;
    logic           emit;
    utlw_pkg::rec_t rec;
  } step_t;

  st_t st_q, st_d;

  function automatic step_t char_done(st_t s, logic [1:0] w, logic [7:0] cap);
    step_t      r;
    logic [8:0] sum;
    r      = '0;
    r.st   = s;
    r.emit = 1'b0;
    sum    = {1'b0, s.units} + 9'(w);
    if (s.lines < LW'(MAX_LINES)) begin
      if (s.idx > s.line_begin && sum > {1'b0, cap}) begin
        r.emit                = 1'b1;
        r.rec.kind            = utlw_pkg::REC_LINE;
        r.rec.line_number     = 3'(s.lines);
        r.rec.first_char      = 7'(s.line_begin);
        r.rec.end_char        = 8'(s.idx);
        r.rec.total_chars     = 8'(s.idx + CW'(1));
        r.rec.total_lines     = 4'(s.lines + LW'(1));
        r.st.lines            = s.lines + LW'(1);
        r.st.line_begin       = s.idx;
        r.st.units            = 8'(w);
      end else begin
        r.st.units = 8'(sum);
      end
    end
    r.st.idx       = s.idx + CW'(1);
    r.st.char_open = 1'b0;
    r.st.len_exp   = 3'd0;
    r.st.len_seen  = 3'd0;
    return r;
  endfunction

  function automatic step_t split_take(st_t s, logic [7:0] b, logic [7:0] cap);
    step_t r;
    st_t   t;
    r      = '0;
    r.st   = s;
    r.emit = 1'b0;
    t      = s;
    if (s.idx < CW'(MAX_CHARS)) begin
      if (!s.char_open) begin
        t.len_exp  = utlw_pkg::lead_length(b);
        t.len_seen = 3'd1;
        if (t.len_exp == 3'd1) begin
          r = char_done(t, 2'd1, cap);
        end else begin
          t.char_open = 1'b1;
          r.st        = t;
        end
      end else begin
        t.len_seen = s.len_seen + 3'd1;
        if (t.len_seen >= t.len_exp) begin
          r = char_done(t, 2'd2, cap);
        end else begin
          r.st = t;
        end
      end
    end
    return r;
  endfunction

  always_comb begin
    st_t                   s;
    step_t                 r;
    logic                  skip;
    logic [RCW-1:0]        n;
    utlw_pkg::rec_t        res [utlw_pkg::MAX_RES];
    s    = st_q;
    r    = '0;
    skip = 1'b0;
    n    = '0;
    for (int i = 0; i < utlw_pkg::MAX_RES; i++) begin
      res[i] = '0;
    end

    if (s.held) begin
      s.held = 1'b0;
      if (text_byte_i == utlw_pkg::BYTE_LOWER_R || text_byte_i == utlw_pkg::BYTE_LOWER_N) begin
        skip = 1'b1;
      end else begin
        r = split_take(s, utlw_pkg::BYTE_BACKSLASH, cap_i);
        s = r.st;
        if (r.emit) begin
          res[n] = r.rec;
          n      = n + RCW'(1);
        end
      end
    end

    if (!skip) begin
      if (text_byte_i == utlw_pkg::BYTE_CR || text_byte_i == utlw_pkg::BYTE_LF) begin
        s.held = 1'b0;
      end else if (text_byte_i == utlw_pkg::BYTE_BACKSLASH) begin
        s.held = 1'b1;
      end else begin
        r = split_take(s, text_byte_i, cap_i);
        s = r.st;
        if (r.emit) begin
          res[n] = r.rec;
          n      = n + RCW'(1);
        end
      end
    end

    if (is_final_i) begin
      if (s.held) begin
        s.held = 1'b0;
        r      = split_take(s, utlw_pkg::BYTE_BACKSLASH, cap_i);
        s      = r.st;
        if (r.emit) begin
          res[n] = r.rec;
          n      = n + RCW'(1);
        end
      end
      if (s.char_open) begin
        r = char_done(s, (s.len_seen > 3'd1) ? 2'd2 : 2'd1, cap_i);
        s = r.st;
        if (r.emit) begin
          res[n] = r.rec;
          n      = n + RCW'(1);
        end
      end
      if (s.line_begin < s.idx && s.lines < LW'(MAX_LINES)) begin
        res[n].kind        = utlw_pkg::REC_LINE;
        res[n].line_number = 3'(s.lines);
        res[n].first_char  = 7'(s.line_begin);
        res[n].end_char    = 8'(s.idx);
        res[n].total_chars = 8'(s.idx);
        res[n].total_lines = 4'(s.lines + LW'(1));
        s.lines            = s.lines + LW'(1);
        n                  = n + RCW'(1);
      end
      res[n].kind        = utlw_pkg::REC_SUMMARY;
      res[n].line_number = 3'd0;
      res[n].first_char  = 7'd0;
      res[n].end_char    = 8'd0;
      res[n].total_chars = 8'(s.idx);
      res[n].total_lines = 4'(s.lines);
      n                  = n + RCW'(1);
      s                  = '0;
    end

    st_d      = s;
    res_o     = res;
    res_cnt_o = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (take_i) begin
      st_q <= st_d;
    end
  end

endmodule

`default_nettype wire

// File: design/utf8_text_line_wrapper.sv
// UTF-8 text line wrapper top level: config register, record buffer, handshakes.
// A taken byte's records appear in the next cycle, one per cycle while ready.
// Throughput: one byte per cycle while bytes make no records; a byte with N
// records holds the input until the last of them is being taken.
// Reset clears all text state and empties the buffer; cap_q returns to 32.
// Depends on utlw_pkg, utlw_if and utlw_core.
`default_nettype none

module utf8_text_line_wrapper #(
  parameter int unsigned MAX_CHARS = utlw_pkg::MAX_CHARS_DEF,
  parameter int unsigned MAX_LINES = utlw_pkg::MAX_LINES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  utlw_in_if.sink          in_i,
  utlw_out_if.source       out_o
);

  localparam int unsigned RCW = utlw_pkg::RES_CNT_W;

  logic [7:0]            cap_q;
  utlw_pkg::rec_t        res_d [utlw_pkg::MAX_RES];
  utlw_pkg::rec_t        res_q [utlw_pkg::MAX_RES];
  logic [RCW-1:0]        cnt_d;
  logic [RCW-1:0]        cnt_q;
  logic [RCW-1:0]        rd_q;
  logic [RCW-1:0]        rd_idx;
  logic                  buf_valid;
  logic                  last_out;
  logic                  take;
  logic                  out_fire;
  utlw_pkg::rec_t        cur;

  assign buf_valid = (rd_q != cnt_q);
  assign last_out  = ((rd_q + RCW'(1)) == cnt_q);
  assign out_fire  = buf_valid && out_o.ready;
  assign in_i.ready = !buf_valid || (last_out && out_o.ready);
  assign take      = in_i.valid && in_i.ready;

  assign rd_idx = buf_valid ? rd_q : '0;
  assign cur    = res_q[rd_idx];

  assign out_o.valid       = buf_valid;
  assign out_o.record_kind = cur.kind;
  assign out_o.line_number = cur.line_number;
  assign out_o.first_char  = cur.first_char;
  assign out_o.end_char    = cur.end_char;
  assign out_o.total_chars = cur.total_chars;
  assign out_o.total_lines = cur.total_lines;
  assign out_o.run_end     = last_out;

  utlw_core #(
    .MAX_CHARS (MAX_CHARS),
    .MAX_LINES (MAX_LINES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .text_byte_i (in_i.text_byte),
    .is_final_i  (in_i.is_final),
    .cap_i       (cap_q),
    .res_o       (res_d),
    .res_cnt_o   (cnt_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= utlw_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (take) begin
      cnt_q <= cnt_d;
      rd_q  <= '0;
    end else if (out_fire) begin
      rd_q <= rd_q + RCW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Testbench for utf8_text_line_wrapper: directed and random texts go in, and a line-wrap
// predictor inside a small scoreboard checks every line and summary record that comes out.
// Depends on utlw_pkg, utlw_if and the utf8_text_line_wrapper RTL.
module testbench;
  import utlw_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;

  typedef struct packed {
    rec_t rec;
    logic run_end;
  } wrap_rec_t;

  class wrap_scoreboard;
    logic [7:0]  cap;
    bit          esc_held;
    bit          in_char;
    int unsigned need_len;
    int unsigned got_len;
    int unsigned n_chars;
    int unsigned line_start;
    int unsigned units;
    int unsigned n_lines;
    wrap_rec_t   pending[$];
    int unsigned errors;

    function new();
      cap = CAP_RESET;
      errors = 0;
      clear_text();
    endfunction

    function void clear_text();
      esc_held = 0;
      in_char = 0;
      need_len = 0;
      got_len = 0;
      n_chars = 0;
      line_start = 0;
      units = 0;
      n_lines = 0;
    endfunction

    function int unsigned seq_len(logic [7:0] b);
      casez (b)
        8'b0???????: return 1;
        8'b110?????: return 2;
        8'b1110????: return 3;
        8'b11110???: return 4;
        default:     return 1;
      endcase
    endfunction

    function void add_record(rec_kind_e k, int unsigned ln, int unsigned first,
                             int unsigned stop_at, int unsigned chars, int unsigned lines);
      wrap_rec_t r;
      r.rec.kind        = k;
      r.rec.line_number = ln[2:0];
      r.rec.first_char  = first[6:0];
      r.rec.end_char    = stop_at[7:0];
      r.rec.total_chars = chars[7:0];
      r.rec.total_lines = lines[3:0];
      r.run_end         = 1'b0;
      pending.push_back(r);
    endfunction

    function void close_char(int unsigned w);
      if (n_lines < MAX_LINES_DEF) begin
        if (n_chars > line_start && units + w > cap) begin
          n_lines++;
          add_record(REC_LINE, n_lines - 1, line_start, n_chars, n_chars + 1, n_lines);
          line_start = n_chars;
          units = 0;
        end
        units = (units + w) & 8'hFF;
      end
      n_chars++;
      in_char = 0;
      need_len = 0;
      got_len = 0;
    endfunction

    function void take_char_byte(logic [7:0] b);
      if (n_chars >= MAX_CHARS_DEF) return;
      if (!in_char) begin
        need_len = seq_len(b);
        got_len = 1;
        if (need_len == 1) close_char(1);
        else in_char = 1;
      end else begin
        got_len++;
        if (got_len >= need_len) close_char(2);
      end
    endfunction

    // one accepted request: works out every record it causes
    function void note_byte(logic [7:0] b, logic fin);
      int unsigned start;
      bit          dropped;
      wrap_rec_t   tail;
      start = pending.size();
      dropped = 0;
      if (esc_held) begin
        esc_held = 0;
        if (b == BYTE_LOWER_R || b == BYTE_LOWER_N) dropped = 1;
        else take_char_byte(BYTE_BACKSLASH);
      end
      if (!dropped && b != BYTE_CR && b != BYTE_LF) begin
        if (b == BYTE_BACKSLASH) esc_held = 1;
        else take_char_byte(b);
      end
      if (fin) begin
        if (esc_held) begin
          esc_held = 0;
          take_char_byte(BYTE_BACKSLASH);
        end
        if (in_char) close_char(got_len > 1 ? 2 : 1);
        if (line_start < n_chars && n_lines < MAX_LINES_DEF) begin
          n_lines++;
          add_record(REC_LINE, n_lines - 1, line_start, n_chars, n_chars, n_lines);
        end
        add_record(REC_SUMMARY, 0, 0, 0, n_chars, n_lines);
        clear_text();
      end
      if (pending.size() > start) begin
        tail = pending.pop_back();
        tail.run_end = 1'b1;
        pending.push_back(tail);
      end
    endfunction

    function void show(string tag, wrap_rec_t r);
      $display("  %s: kind=%0d line=%0d first=%0d end=%0d chars=%0d lines=%0d run_end=%0d",
               tag, r.rec.kind, r.rec.line_number, r.rec.first_char, r.rec.end_char,
               r.rec.total_chars, r.rec.total_lines, r.run_end);
    endfunction

    function void check_record(wrap_rec_t got);
      wrap_rec_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("record with nothing expected");
          show("actual", got);
        end
        return;
      end
      want = pending.pop_front();
      if (want !== got) begin
        errors++;
        if (errors <= 10) begin
          $display("record mismatch");
          show("expected", want);
          show("actual  ", got);
        end
      end
    endfunction

    function void check_leftover();
      while (pending.size() != 0) begin
        errors++;
        if (errors <= 10) begin
          $display("expected record never came");
          show("expected", pending[0]);
        end
        void'(pending.pop_front());
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  utlw_in_if   in_if();
  utlw_out_if  out_if();

  wrap_scoreboard sb;
  wrap_rec_t      seen;
  int unsigned    quiet;
  int unsigned    tx_odds;
  int unsigned    rx_odds;

  utf8_text_line_wrapper uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    sb = new();
    quiet = 0;
    tx_odds = 0;
    rx_odds = 0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= CAP_RESET;
    in_if.valid <= 1'b0;
    in_if.text_byte <= 8'h00;
    in_if.is_final <= 1'b0;
    out_if.ready <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // record sink with random stall bursts
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_odds != 0 && $urandom_range(0, rx_odds - 1) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        seen.rec.kind        = rec_kind_e'(out_if.record_kind);
        seen.rec.line_number = out_if.line_number;
        seen.rec.first_char  = out_if.first_char;
        seen.rec.end_char    = out_if.end_char;
        seen.rec.total_chars = out_if.total_chars;
        seen.rec.total_lines = out_if.total_lines;
        seen.run_end         = out_if.run_end;
        sb.check_record(seen);
      end
      if (in_if.valid && in_if.ready) sb.note_byte(in_if.text_byte, in_if.is_final);
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (tx_odds != 0 && $urandom_range(0, tx_odds - 1) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.text_byte <= b;
    in_if.is_final <= fin;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_cap(input logic [7:0] v);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.cap = v;
  endtask

  task automatic send_list(input logic [7:0] txt[$]);
    for (int i = 0; i < txt.size(); i++) send_byte(txt[i], i == txt.size() - 1);
  endtask

  // random text: printables (share set by plain), multi-byte chars, escapes, raw CR/LF, noise
  task automatic send_text(input int unsigned len, input int unsigned plain);
    logic [7:0]  txt[$];
    int unsigned pick;
    int unsigned nb;
    while (txt.size() < len) begin
      if ($urandom_range(0, 99) < plain) begin
        txt.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          nb = $urandom_range(2, 4);
          case (nb)
            2: txt.push_back(8'($urandom_range(8'hC0, 8'hDF)));
            3: txt.push_back(8'($urandom_range(8'hE0, 8'hEF)));
            default: txt.push_back(8'($urandom_range(8'hF0, 8'hF7)));
          endcase
          for (int k = 1; k < nb; k++) txt.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end else if (pick < 60) begin
          txt.push_back(BYTE_BACKSLASH);
          case ($urandom_range(0, 3))
            0: txt.push_back(BYTE_LOWER_R);
            1: txt.push_back(BYTE_LOWER_N);
            2: txt.push_back(BYTE_BACKSLASH);
            default: txt.push_back(8'($urandom));
          endcase
        end else if (pick < 75) begin
          txt.push_back($urandom_range(0, 1) ? BYTE_CR : BYTE_LF);
        end else begin
          txt.push_back(8'($urandom));
        end
      end
    end
    while (txt.size() > len) void'(txt.pop_back());
    for (int i = 0; i < txt.size(); i++) begin
      if (i != 0 && $urandom_range(0, 24) == 0) drain();
      send_byte(txt[i], i == txt.size() - 1);
    end
  endtask

  function automatic int unsigned pick_odds();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 4;
      default: return 12;
    endcase
  endfunction

  initial begin
    logic [7:0]  cap_plan[5];
    int unsigned sent;
    int unsigned len;
    @(posedge rst_ni);
    @(posedge clk_i);

    // empty text at the reset cap
    send_list('{BYTE_CR});
    write_cap(8'd3);
    // zero byte, invalid lead, stray continuation, 2/3/4-byte chars, escapes, raw LF,
    // backslash kept before a plain letter, backslash standing last
    send_list('{8'h00, 8'hFF, 8'h80, 8'hC3, 8'hA9, BYTE_BACKSLASH, BYTE_LOWER_N,
                BYTE_BACKSLASH, BYTE_LOWER_R, BYTE_LF, BYTE_BACKSLASH, 8'h41,
                8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h7F, BYTE_BACKSLASH});
    // truncated characters: two bytes, then the lead alone
    send_list('{8'hE2, 8'h82});
    send_list('{8'hF0});

    cap_plan = '{8'd1, 8'd255, 8'd2, 8'($urandom_range(3, 40)), 8'd5};
    for (int p = 0; p < 5; p++) begin
      write_cap(cap_plan[p]);
      sent = 0;
      if (p == 1) begin
        tx_odds = pick_odds();
        rx_odds = pick_odds();
        send_text(105, 85);
      end
      while (sent < 50) begin
        if (p == 4) begin
          tx_odds = 0;
          rx_odds = 0;
        end else begin
          tx_odds = pick_odds();
          rx_odds = pick_odds();
        end
        len = $urandom_range(1, 30);
        send_text(len, 40);
        sent += len;
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    sb.check_leftover();
    if (sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

// File: utf8_text_line_wrapper.f
design/utlw_pkg.sv
design/utlw_if.sv
design/utlw_core.sv
design/utf8_text_line_wrapper.sv
bench/testbench.sv
